FILE: hdl/robin_boundary_gradient_core_assert.svh
// Assertion macros for the boundary gradient core
`ifndef ROBIN_BOUNDARY_GRADIENT_CORE_ASSERT_SVH
`define ROBIN_BOUNDARY_GRADIENT_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RBG_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> cons) \
        else $error("assertion failed");
`define RBG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RBG_ASSERT_IMP(lbl, ante, cons)
`define RBG_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: hdl/rbg_pkg.sv
// Types, register indexes and helpers of the boundary gradient core
`default_nettype none
package rbg_pkg;

    typedef logic [2:0] t_reg_idx;

    localparam t_reg_idx REG_DIR_X   = 3'd0;
    localparam t_reg_idx REG_DIR_Y   = 3'd1;
    localparam t_reg_idx REG_DIR_Z   = 3'd2;
    localparam t_reg_idx REG_HTC     = 3'd3;
    localparam t_reg_idx REG_AMBIENT = 3'd4;
    localparam t_reg_idx REG_FLUX_C0 = 3'd5;
    localparam t_reg_idx REG_FLUX_C1 = 3'd6;
    localparam t_reg_idx REG_FLUX_C2 = 3'd7;

    // quotient bits kept by the divider: enough to see a 32-bit overflow
    localparam int QBITS = 33;

    // one divider stage: partial remainder, divisor, quotient so far
    typedef struct packed {
        logic [31:0]      rem;
        logic [31:0]      den;
        logic [QBITS-1:0] quo;
        logic [QBITS-1:0] lo;
        logic             neg;
        logic             zero;
        logic             ovf;
        logic             npos;
        logic             nneg;
    } t_div_stage;

    // clip a 66-bit signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        logic signed [31:0] res;
        if (x > 66'sh0_7FFF_FFFF)
            res = 32'sh7FFF_FFFF;
        else if (x < -66'sh0_8000_0000)
            res = 32'sh8000_0000;
        else
            res = x[31:0];
        return res;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/robin_boundary_gradient_core.sv
// Pipelined convective boundary gradient core, one face per clock.
//
// Accepts one face per cycle while busy is low (it always is once out of
// reset) and returns one result per face, in order, on a one-cycle o_done
// strobe: the arithmetic stages and the divider entry register feed a
// 33-stage restoring divider that settles one quotient bit per stage, then
// an output register. The receiver cannot stall, so the result must be
// taken in the strobe cycle. Configuration writes apply at once and must
// only be made with no face in flight.
`default_nettype none
module robin_boundary_gradient_core #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire rbg_pkg::t_reg_idx     i_cfg_addr,
    input  wire logic [31:0]           i_cfg_wdata,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic signed [31:0]    i_centre_x,
    input  wire logic signed [31:0]    i_centre_y,
    input  wire logic signed [31:0]    i_centre_z,
    input  wire logic signed [31:0]    i_face_temp,
    input  wire logic signed [31:0]    i_conductivity,
    output logic                       o_done,
    output logic signed [31:0]         o_boundary_gradient,
    output logic                       o_saturated
);
    import rbg_pkg::*;

    localparam int NW        = 68 - FRAC_BITS;
    localparam int DIV_STEPS = QBITS;
    localparam int LAT       = 8 + DIV_STEPS + 1;

    // configuration registers
    logic signed [31:0] r_dir_x, r_dir_y, r_dir_z, r_htc, r_ambient;
    logic signed [31:0] r_flux_c0, r_flux_c1, r_flux_c2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir_x   <= '0;
            r_dir_y   <= '0;
            r_dir_z   <= '0;
            r_htc     <= '0;
            r_ambient <= '0;
            r_flux_c0 <= '0;
            r_flux_c1 <= '0;
            r_flux_c2 <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_DIR_X:   r_dir_x   <= i_cfg_wdata;
                REG_DIR_Y:   r_dir_y   <= i_cfg_wdata;
                REG_DIR_Z:   r_dir_z   <= i_cfg_wdata;
                REG_HTC:     r_htc     <= i_cfg_wdata;
                REG_AMBIENT: r_ambient <= i_cfg_wdata;
                REG_FLUX_C0: r_flux_c0 <= i_cfg_wdata;
                REG_FLUX_C1: r_flux_c1 <= i_cfg_wdata;
                REG_FLUX_C2: r_flux_c2 <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // valid bits of the arithmetic and divider stages
    logic [7:1] r_v;
    logic [DIV_STEPS:0] r_dv_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v    <= '0;
            r_dv_v <= '0;
            o_done <= 1'b0;
        end else begin
            r_v    <= {r_v[6:1], start && !busy};
            r_dv_v <= {r_dv_v[DIV_STEPS-1:0], r_v[7]};
            o_done <= r_dv_v[DIV_STEPS];
        end
    end

    // stage 1: projection products and temperature difference
    logic signed [63:0] r1_px, r1_py, r1_pz;
    logic signed [32:0] r1_dt;
    logic signed [31:0] r1_kap;
    // stage 2: location and convective product
    logic signed [31:0] r2_loc, r2_kap;
    logic signed [64:0] r2_hd;
    logic signed [65:0] n2_sum;
    // stage 3: location squared and linear flux product
    logic signed [63:0] r3_ll, r3_c1l;
    logic signed [64:0] r3_hd;
    logic signed [31:0] r3_kap;
    // stage 4: clipped square, shifted terms
    logic signed [31:0] r4_loc2, r4_kap;
    logic signed [NW-1:0] r4_c1s, r4_hds;
    // stage 5: quadratic flux product
    logic signed [63:0] r5_c2l;
    logic signed [NW-1:0] r5_c1s, r5_hds;
    logic signed [31:0] r5_kap;
    // stage 6: numerator
    logic signed [NW-1:0] r6_num;
    logic signed [31:0] r6_kap;
    // stage 7: magnitudes and signs
    logic [NW-1:0] r7_mag;
    logic [31:0]   r7_den;
    logic          r7_neg, r7_zero, r7_npos, r7_nneg;
    // divider entry
    logic [NW-1:0]      n8_hi;
    logic [NW+FRAC_BITS-1:0] n8_sh;
    t_div_stage r_dv [0:DIV_STEPS];
    t_div_stage n_dv [0:DIV_STEPS];

    assign n2_sum = 66'(r1_px >>> FRAC_BITS) + 66'(r1_py >>> FRAC_BITS)
                  + 66'(r1_pz >>> FRAC_BITS);
    assign n8_hi  = r7_mag >> (QBITS - FRAC_BITS);
    assign n8_sh  = (NW + FRAC_BITS)'(r7_mag) << FRAC_BITS;

    // advance the arithmetic stages
    always_ff @(posedge i_clk) begin
        r1_px  <= 64'(i_centre_x) * 64'(r_dir_x);
        r1_py  <= 64'(i_centre_y) * 64'(r_dir_y);
        r1_pz  <= 64'(i_centre_z) * 64'(r_dir_z);
        r1_dt  <= 33'(i_face_temp) - 33'(r_ambient);
        r1_kap <= i_conductivity;

        r2_loc <= sat32(n2_sum);
        r2_hd  <= 65'(r1_dt) * 65'(r_htc);
        r2_kap <= r1_kap;

        r3_ll  <= 64'(r2_loc) * 64'(r2_loc);
        r3_c1l <= 64'(r_flux_c1) * 64'(r2_loc);
        r3_hd  <= r2_hd;
        r3_kap <= r2_kap;

        r4_loc2 <= sat32(66'(r3_ll >>> FRAC_BITS));
        r4_c1s  <= NW'(r3_c1l >>> FRAC_BITS);
        r4_hds  <= NW'(r3_hd >>> FRAC_BITS);
        r4_kap  <= r3_kap;

        r5_c2l <= 64'(r_flux_c2) * 64'(r4_loc2);
        r5_c1s <= r4_c1s;
        r5_hds <= r4_hds;
        r5_kap <= r4_kap;

        r6_num <= NW'(r_flux_c0) + r5_c1s + NW'(r5_c2l >>> FRAC_BITS) - r5_hds;
        r6_kap <= r5_kap;

        r7_mag  <= r6_num[NW-1] ? NW'(-r6_num) : NW'(r6_num);
        r7_den  <= r6_kap[31] ? 32'(-r6_kap) : 32'(r6_kap);
        r7_neg  <= r6_num[NW-1] != r6_kap[31];
        r7_zero <= (r6_kap == '0);
        r7_npos <= !r6_num[NW-1] && (r6_num != '0);
        r7_nneg <= r6_num[NW-1];
    end

    // load the divider (top part must stay below the divisor), then settle
    // one quotient bit per restoring stage
    always_comb begin
        logic [32:0] trial;
        logic        take;
        n_dv[0].rem  = n8_hi[31:0];
        n_dv[0].den  = r7_den;
        n_dv[0].quo  = '0;
        n_dv[0].lo   = n8_sh[QBITS-1:0];
        n_dv[0].neg  = r7_neg;
        n_dv[0].zero = r7_zero;
        n_dv[0].ovf  = (n8_hi >= NW'(r7_den));
        n_dv[0].npos = r7_npos;
        n_dv[0].nneg = r7_nneg;
        for (int k = 1; k <= DIV_STEPS; k++) begin
            trial       = {r_dv[k-1].rem, r_dv[k-1].lo[QBITS-1]};
            take        = (trial >= {1'b0, r_dv[k-1].den});
            n_dv[k]     = r_dv[k-1];
            n_dv[k].rem = take ? 32'(trial - {1'b0, r_dv[k-1].den}) : trial[31:0];
            n_dv[k].quo = {r_dv[k-1].quo[QBITS-2:0], take};
            n_dv[k].lo  = {r_dv[k-1].lo[QBITS-2:0], 1'b0};
        end
    end

    // advance the divider stages
    always_ff @(posedge i_clk) begin
        for (int k = 0; k <= DIV_STEPS; k++)
            r_dv[k] <= n_dv[k];
    end

    // handle a zero divisor, clip the quotient and apply the sign
    t_div_stage          n_fin;
    logic signed [31:0]  n_grad;
    logic                n_sat;

    assign n_fin = r_dv[DIV_STEPS];

    always_comb begin
        priority if (n_fin.zero) begin
            n_sat  = 1'b1;
            n_grad = n_fin.npos ? 32'sh7FFF_FFFF :
                     (n_fin.nneg ? 32'sh8000_0000 : 32'sh0);
        end else if (n_fin.neg) begin
            n_sat  = n_fin.ovf || (n_fin.quo > 33'h0_8000_0000);
            n_grad = n_sat ? 32'sh8000_0000 : 32'(-n_fin.quo);
        end else begin
            n_sat  = n_fin.ovf || (n_fin.quo > 33'h0_7FFF_FFFF);
            n_grad = n_sat ? 32'sh7FFF_FFFF : n_fin.quo[31:0];
        end
    end

    // hold the result for its strobe cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_saturated <= 1'b0;
        end else begin
            o_saturated <= r_dv_v[DIV_STEPS] && n_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        o_boundary_gradient <= n_grad;
    end

`include "robin_boundary_gradient_core_assert.svh"

    `RBG_ASSERT_IMP(a_latency, start && !busy, ##LAT o_done)
    `RBG_ASSERT_NEXT(a_zero_sat, r_dv_v[DIV_STEPS] && n_fin.zero, o_done && o_saturated)
    `RBG_ASSERT_IMP(a_sat_strobe, o_saturated, o_done)

endmodule
`default_nettype wire
